// ----- rtl/sorted_region_table_allocator_assert.svh -----
// Assertion macros shared by the region table allocator RTL.
// Define NO_ASSERTIONS to compile every macro below to nothing.
`ifndef SORTED_REGION_TABLE_ALLOCATOR_ASSERT_SVH
`define SORTED_REGION_TABLE_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define SRTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Consequence checked in the cycle after the antecedent.
`define SRTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SRTA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/srta_pkg.sv -----
// Package of the region table allocator: codes, types and default sizes.
// Used by sorted_region_table_allocator and its testbench; depends on nothing.
`timescale 1ns / 1ps
package srta_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int ADDR_BITS_DEF   = 48;

  localparam int HANDLE_W = 48;
  localparam int FIELD_W  = 48;
  localparam int ALIGN_W  = 6;
  localparam int TYPE_W   = 3;
  localparam int ALMATH_W = 64;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 56;

  localparam logic [TYPE_W-1:0] TYPE_USABLE    = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_ALLOCATOR = 3'd1;

  typedef enum logic [1:0] {
    KIND_CREATE   = 2'd0,
    KIND_RESERVE  = 2'd1,
    KIND_ALLOCATE = 2'd2,
    KIND_FREE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_NOMEM   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_CALC_END,
    S_CALC_REM,
    S_DECIDE,
    S_RD,
    S_EMIT,
    S_TAIL,
    S_FLUSH,
    S_DONE
  } state_e;

endpackage

// ----- rtl/srta_ram.sv -----
// One bank of the region table: single write port, single registered read port.
// Generic storage; no package dependency.
`timescale 1ns / 1ps
module srta_ram #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 99
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

// ----- rtl/sorted_region_table_allocator.sv -----
// Top level of the sorted region table allocator.
// Depends on srta_pkg, srta_ram and sorted_region_table_allocator_assert.svh.
`timescale 1ns / 1ps
`include "sorted_region_table_allocator_assert.svh"
// The block keeps up to MAX_REGIONS regions sorted by start and handles one
// operation at a time: create, reserve, allocate or free. Each operation with
// valid arguments makes one scan of the table through a pipelined read, the
// arithmetic states (end, remainder, decide), and, when the table changes, a
// copy pass that streams every entry into the other of two table banks,
// inserting split pieces and merging adjacent usable regions on the way. A
// rejected argument answers without a scan. The input is not ready while an
// operation is in progress. There is no clearing pass after reset: only
// entries below the entry count are ever used.
module sorted_region_table_allocator #(
  parameter int MAX_REGIONS = srta_pkg::MAX_REGIONS_DEF,
  parameter int ADDR_BITS   = srta_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // start_address[47:0], length[95:48], align_log2[101:96], region_type[104:102]
  input  logic [srta_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status[1:0], handle[49:2]
  output logic [srta_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import srta_pkg::*;

  localparam int A      = ADDR_BITS;
  localparam int IDX_W  = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int DW     = 2 * A + TYPE_W;

  state_e state_q, state_d;

  // operation registers
  kind_e                kind_q;
  logic [A-1:0]         s_q, l_q;
  logic [TYPE_W-1:0]    t_q;
  logic [A:0]           end_q;
  logic [ALIGN_W-1:0]   k_q;
  logic [ALMATH_W-1:0]  amask_q;

  logic [CNT_W-1:0]     count_q, ra_q, w_q, pos_q;
  logic                 bank_q;

  // scan pipeline
  logic                 p1_v_q, p2_v_q;
  logic [IDX_W-1:0]     p1_idx_q, p2_idx_q;
  logic [A-1:0]         p2_rs_q;
  logic [TYPE_W-1:0]    p2_rt_q;
  logic [A:0]           p2_rend_q;
  logic [ALMATH_W-1:0]  p2_up_q;
  logic                 p2_upovf_q;

  // scan results
  logic                 found_q, bad_q;
  logic [IDX_W-1:0]     f_idx_q;
  logic [A-1:0]         f_rs_q, f_rend_q, f_up_q;
  logic [TYPE_W-1:0]    f_rt_q;

  logic [A-1:0]         cs_q, cend_q, left_q, right_q;
  logic [1:0]           sub_q;

  // merge accumulator
  logic                 acc_v_q;
  logic [A-1:0]         acc_start_q, acc_len_q, acc_end_q;
  logic [TYPE_W-1:0]    acc_type_q;

  status_e              res_status_q;
  logic [HANDLE_W-1:0]  res_handle_q;
  logic                 m_valid_q;
  status_e              m_status_q;
  logic [HANDLE_W-1:0]  m_handle_q;

  // memory ports
  logic [DW-1:0]        rd0, rd1, src;
  logic [A-1:0]         src_start, src_len;
  logic [TYPE_W-1:0]    src_type;
  logic                 wr_en;
  logic [DW-1:0]        wr_data;

  // control from the output decode
  logic                 accept, scan_issue, scan_end, last_sub, out_load;
  logic                 e_v, mrg, push;
  logic [A-1:0]         e_start, e_len, e_end;
  logic [TYPE_W-1:0]    e_type, claim_type;
  logic                 arg_bad;
  logic [1:0]           need;
  logic                 room_claim, is_tgt;

  // inputs
  logic [A-1:0]         s_in, l_in;

  assign s_in = A'(s_axis_tdata_i[47:0]);
  assign l_in = A'(s_axis_tdata_i[95:48]);

  srta_ram #(.DEPTH(MAX_REGIONS), .DATA_W(DW)) u_bank0 (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en & bank_q),
    .wr_addr_i (w_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (ra_q[IDX_W-1:0]),
    .rd_data_o (rd0)
  );

  srta_ram #(.DEPTH(MAX_REGIONS), .DATA_W(DW)) u_bank1 (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en & ~bank_q),
    .wr_addr_i (w_q[IDX_W-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (ra_q[IDX_W-1:0]),
    .rd_data_o (rd1)
  );

  assign src       = bank_q ? rd1 : rd0;
  assign src_start = src[A-1:0];
  assign src_len   = src[2*A-1:A];
  assign src_type  = src[DW-1:2*A];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - HANDLE_W - 2){1'b0}}, m_handle_q, m_status_q};

  assign scan_issue = (state_q == S_SCAN) && (ra_q < count_q);
  assign scan_end   = (ra_q == count_q) && !p1_v_q && !p2_v_q;
  assign claim_type = (kind_q == KIND_RESERVE) ? t_q : TYPE_ALLOCATOR;
  assign need       = {1'b0, (left_q != '0)} + {1'b0, (right_q != '0)};
  assign room_claim = ({1'b0, count_q} + (CNT_W + 1)'(need)) <= (CNT_W + 1)'(MAX_REGIONS);
  assign is_tgt     = found_q && (ra_q[IDX_W-1:0] == f_idx_q);

  always_comb begin
    unique case (kind_q)
      KIND_CREATE:   arg_bad = (l_q == '0) || end_q[A];
      KIND_RESERVE:  arg_bad = (t_q == TYPE_USABLE) || (l_q == '0) || end_q[A];
      KIND_ALLOCATE: arg_bad = (t_q == TYPE_USABLE) || (l_q == '0);
      default:       arg_bad = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (accept) state_d = S_CHECK;
      S_CHECK:    state_d = arg_bad ? S_DONE : S_SCAN;
      S_SCAN:     if (scan_end) state_d = S_CALC_END;
      S_CALC_END: state_d = S_CALC_REM;
      S_CALC_REM: state_d = S_DECIDE;
      S_DECIDE: begin
        unique case (kind_q)
          KIND_CREATE: begin
            state_d = (bad_q || count_q == CNT_W'(MAX_REGIONS)) ? S_DONE : S_RD;
          end
          KIND_RESERVE: begin
            state_d = (found_q && f_rt_q == TYPE_USABLE && room_claim) ? S_RD : S_DONE;
          end
          KIND_ALLOCATE: state_d = (found_q && room_claim) ? S_RD : S_DONE;
          default:       state_d = found_q ? S_RD : S_DONE;
        endcase
      end
      S_RD:       state_d = (ra_q == count_q) ? S_TAIL : S_EMIT;
      S_EMIT:     if (last_sub) state_d = S_RD;
      S_TAIL:     state_d = S_FLUSH;
      S_FLUSH:    state_d = S_DONE;
      S_DONE:     if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: the entry stream of the copy pass and the merge.
  always_comb begin
    e_v      = 1'b0;
    e_start  = src_start;
    e_len    = src_len;
    e_type   = src_type;
    last_sub = 1'b1;
    if (state_q == S_EMIT) begin
      e_v = 1'b1;
      unique case (kind_q)
        KIND_CREATE: begin
          if (ra_q == pos_q && sub_q == 2'd0) begin
            e_start  = s_q;
            e_len    = l_q;
            e_type   = t_q;
            last_sub = 1'b0;
          end
        end
        KIND_RESERVE, KIND_ALLOCATE: begin
          if (is_tgt) begin
            last_sub = (sub_q == 2'd2);
            case (sub_q)
              2'd0: begin
                e_v     = (left_q != '0);
                e_start = f_rs_q;
                e_len   = left_q;
                e_type  = f_rt_q;
              end
              2'd1: begin
                e_start = cs_q;
                e_len   = l_q;
                e_type  = claim_type;
              end
              default: begin
                e_v     = (right_q != '0);
                e_start = cend_q;
                e_len   = right_q;
                e_type  = f_rt_q;
              end
            endcase
          end
        end
        default: begin
          if (is_tgt) e_type = TYPE_USABLE;
        end
      endcase
    end else if (state_q == S_TAIL) begin
      e_v     = (kind_q == KIND_CREATE) && (pos_q == count_q);
      e_start = s_q;
      e_len   = l_q;
      e_type  = t_q;
    end
    e_end    = e_start + e_len;
    mrg      = acc_v_q && (acc_type_q == TYPE_USABLE) && (e_type == TYPE_USABLE) &&
               (acc_end_q == e_start);
    push     = e_v && !mrg && acc_v_q;
    wr_en    = push || ((state_q == S_FLUSH) && acc_v_q);
    wr_data  = {acc_type_q, acc_len_q, acc_start_q};
    out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      bank_q    <= 1'b0;
      m_valid_q <= 1'b0;
      p1_v_q    <= 1'b0;
      p2_v_q    <= 1'b0;
      acc_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_v_q  <= scan_issue;
      p2_v_q  <= p1_v_q;
      if (state_q == S_DECIDE) begin
        acc_v_q <= 1'b0;
      end else if (e_v) begin
        acc_v_q <= 1'b1;
      end
      if (state_q == S_FLUSH) begin
        count_q <= w_q + CNT_W'(acc_v_q);
        bank_q  <= ~bank_q;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(s_axis_tuser_i);
      s_q    <= s_in;
      l_q    <= l_in;
      k_q    <= s_axis_tdata_i[101:96];
      t_q    <= s_axis_tdata_i[104:102];
      end_q  <= {1'b0, s_in} + {1'b0, l_in};
    end

    // Scan stage one: region end and aligned-up start.
    p1_idx_q   <= ra_q[IDX_W-1:0];
    p2_idx_q   <= p1_idx_q;
    p2_rs_q    <= src_start;
    p2_rt_q    <= src_type;
    p2_rend_q  <= {1'b0, src_start} + {1'b0, src_len};
    {p2_upovf_q, p2_up_q} <= {1'b0, ALMATH_W'(src_start)} + {1'b0, amask_q};

    if (scan_issue) ra_q <= ra_q + 1'b1;

    unique case (state_q)
      S_CHECK: begin
        amask_q      <= (ALMATH_W'(1) << k_q) - ALMATH_W'(1);
        ra_q         <= '0;
        found_q      <= 1'b0;
        bad_q        <= 1'b0;
        pos_q        <= '0;
        res_status_q <= arg_bad ? STATUS_INVALID : STATUS_OK;
        res_handle_q <= '0;
      end
      S_CALC_END: begin
        cs_q   <= (kind_q == KIND_RESERVE) ? s_q : f_up_q;
        cend_q <= ((kind_q == KIND_RESERVE) ? s_q : f_up_q) + l_q;
      end
      S_CALC_REM: begin
        left_q  <= cs_q - f_rs_q;
        right_q <= f_rend_q - cend_q;
      end
      S_DECIDE: begin
        ra_q  <= '0;
        w_q   <= '0;
        sub_q <= '0;
        unique case (kind_q)
          KIND_CREATE: begin
            if (bad_q) res_status_q <= STATUS_INVALID;
            else if (count_q == CNT_W'(MAX_REGIONS)) res_status_q <= STATUS_NOMEM;
          end
          KIND_RESERVE: begin
            if (!found_q || f_rt_q != TYPE_USABLE) res_status_q <= STATUS_INVALID;
            else if (!room_claim) res_status_q <= STATUS_NOMEM;
            else res_handle_q <= HANDLE_W'(cs_q);
          end
          KIND_ALLOCATE: begin
            if (!found_q || !room_claim) res_status_q <= STATUS_NOMEM;
            else res_handle_q <= HANDLE_W'(cs_q);
          end
          default: begin
            if (!found_q) res_status_q <= STATUS_INVALID;
          end
        endcase
      end
      S_EMIT: begin
        if (last_sub) begin
          ra_q  <= ra_q + 1'b1;
          sub_q <= '0;
        end else begin
          sub_q <= sub_q + 1'b1;
        end
      end
      default: ;
    endcase

    // Scan stage two: per-entry tests, first match kept.
    if (p2_v_q) begin
      logic hit;
      hit = 1'b0;
      unique case (kind_q)
        KIND_CREATE: begin
          if (end_q > {1'b0, p2_rs_q} && p2_rend_q > {1'b0, s_q}) bad_q <= 1'b1;
          if (p2_rs_q < s_q) pos_q <= pos_q + 1'b1;
        end
        KIND_RESERVE: hit = (s_q >= p2_rs_q) && (end_q <= p2_rend_q);
        KIND_ALLOCATE: begin
          hit = (p2_rt_q == TYPE_USABLE) && !p2_upovf_q &&
                (({1'b0, p2_up_q & ~amask_q} + (ALMATH_W + 1)'(l_q)) <=
                 (ALMATH_W + 1)'(p2_rend_q));
        end
        default: hit = (p2_rs_q == s_q);
      endcase
      if (hit && !found_q) begin
        found_q  <= 1'b1;
        f_idx_q  <= p2_idx_q;
        f_rs_q   <= p2_rs_q;
        f_rend_q <= p2_rend_q[A-1:0];
        f_rt_q   <= p2_rt_q;
        f_up_q   <= A'(p2_up_q & ~amask_q);
      end
    end

    // Merge accumulator of the copy pass.
    if (e_v) begin
      if (mrg) begin
        acc_len_q <= acc_len_q + e_len;
      end else begin
        acc_start_q <= e_start;
        acc_len_q   <= e_len;
        acc_type_q  <= e_type;
      end
      acc_end_q <= e_end;
    end
    if (push) w_q <= w_q + 1'b1;

    if (out_load) begin
      m_status_q <= res_status_q;
      m_handle_q <= res_handle_q;
    end
  end

  `SRTA_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CNT_W'(MAX_REGIONS), "entry count past capacity")
  `SRTA_ASSERT_NEXT(a_count_commit, clk_i, rst_ni, state_q != S_FLUSH, $stable(count_q), "count changed outside commit")
  `SRTA_ASSERT(a_write_copy, clk_i, rst_ni, wr_en |-> (state_q == S_EMIT || state_q == S_TAIL || state_q == S_FLUSH), "table write outside copy pass")
  `SRTA_ASSERT(a_handle_fail, clk_i, rst_ni, (m_valid_q && m_status_q != STATUS_OK) |-> (m_handle_q == '0), "nonzero handle on failure")

endmodule

// ----- dv/sorted_region_table_allocator_tb.sv -----
// Self-checking testbench for the sorted region table allocator.
// Depends on srta_pkg and sorted_region_table_allocator; predicts every answer.
`timescale 1ns / 1ps
module sorted_region_table_allocator_tb;
  import srta_pkg::*;

  localparam int NREG = 64;
  localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    kind_e       kind;
    logic [47:0] start_address;
    logic [47:0] length;
    logic [5:0]  align_log2;
    logic [2:0]  region_type;
  } op_t;

  typedef struct packed {
    status_e     status;
    logic [47:0] handle;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  sorted_region_table_allocator uut (.*);

  // Predicted table: kept sorted by start, like the block's.
  logic [63:0] tbl_start [NREG+1];
  logic [63:0] tbl_len   [NREG+1];
  logic [2:0]  tbl_type  [NREG+1];
  int          tbl_count;

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  op_t     cur_op;
  int      gap_left;
  int      stall_left;
  int      mismatches;
  bit      all_sent;
  bit      in_taken = 1'b0;
  int      hold_request;  // when set, the sender waits until every answer is in

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void tbl_insert(input int pos, input logic [63:0] s,
                                     input logic [63:0] l, input logic [2:0] t);
    for (int i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_len[i] = tbl_len[i-1];
      tbl_type[i] = tbl_type[i-1];
    end
    tbl_start[pos] = s;
    tbl_len[pos] = l;
    tbl_type[pos] = t;
    tbl_count++;
  endfunction

  function automatic void tbl_remove(input int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_len[i] = tbl_len[i+1];
      tbl_type[i] = tbl_type[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void coalesce_usable();
    int i;
    i = 0;
    while (i + 1 < tbl_count) begin
      if (tbl_type[i] == TYPE_USABLE && tbl_type[i+1] == TYPE_USABLE &&
          tbl_start[i] + tbl_len[i] == tbl_start[i+1]) begin
        tbl_len[i] += tbl_len[i+1];
        tbl_remove(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic bit claim_range(input int e, input logic [63:0] s,
                                     input logic [63:0] l, input logic [2:0] t);
    logic [63:0] s0, left, right;
    logic [2:0] t0;
    int need;
    s0 = tbl_start[e];
    left = s - s0;
    right = s0 + tbl_len[e] - (s + l);
    t0 = tbl_type[e];
    need = (left != 0) + (right != 0);
    if (tbl_count + need > NREG) return 1'b0;
    tbl_start[e] = s;
    tbl_len[e] = l;
    tbl_type[e] = t;
    if (right != 0) tbl_insert(e + 1, s + l, right, t0);
    if (left != 0) tbl_insert(e, s0, left, t0);
    coalesce_usable();
    return 1'b1;
  endfunction

  function automatic answer_t predict_answer(input op_t op);
    answer_t a;
    logic [63:0] s, l, e, am, up;
    int found, pos;
    s = op.start_address;
    l = op.length;
    e = s + l;
    a.status = STATUS_OK;
    a.handle = '0;
    found = tbl_count;
    case (op.kind)
      KIND_CREATE: begin
        if (l == 0 || e > AMASK) begin
          a.status = STATUS_INVALID;
        end else begin
          pos = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (e > tbl_start[i] && tbl_start[i] + tbl_len[i] > s) a.status = STATUS_INVALID;
            if (tbl_start[i] < s) pos = i + 1;
          end
          if (a.status == STATUS_OK) begin
            if (tbl_count >= NREG) a.status = STATUS_NOMEM;
            else begin
              tbl_insert(pos, s, l, op.region_type);
              coalesce_usable();
            end
          end
        end
      end
      KIND_RESERVE: begin
        if (op.region_type == TYPE_USABLE || l == 0 || e > AMASK) begin
          a.status = STATUS_INVALID;
        end else begin
          for (int i = 0; i < tbl_count; i++)
            if (found == tbl_count && s >= tbl_start[i] && e <= tbl_start[i] + tbl_len[i])
              found = i;
          if (found == tbl_count || tbl_type[found] != TYPE_USABLE) a.status = STATUS_INVALID;
          else if (!claim_range(found, s, l, op.region_type)) a.status = STATUS_NOMEM;
          else a.handle = s[47:0];
        end
      end
      KIND_ALLOCATE: begin
        if (op.region_type == TYPE_USABLE || l == 0) begin
          a.status = STATUS_INVALID;
        end else begin
          am = (64'd1 << op.align_log2) - 1;
          up = 0;
          for (int i = 0; i < tbl_count && found == tbl_count; i++) begin
            logic [63:0] u;
            u = (tbl_start[i] + am) & ~am;
            if (tbl_type[i] == TYPE_USABLE && tbl_len[i] >= l &&
                u - tbl_start[i] <= tbl_len[i] && l <= tbl_len[i] - (u - tbl_start[i])) begin
              found = i;
              up = u;
            end
          end
          if (found == tbl_count) a.status = STATUS_NOMEM;
          else if (!claim_range(found, up, l, TYPE_ALLOCATOR)) a.status = STATUS_NOMEM;
          else a.handle = up[47:0];
        end
      end
      default: begin
        for (int i = 0; i < tbl_count; i++)
          if (found == tbl_count && tbl_start[i] == s) found = i;
        if (found == tbl_count) a.status = STATUS_INVALID;
        else begin
          tbl_type[found] = TYPE_USABLE;
          coalesce_usable();
        end
      end
    endcase
    return a;
  endfunction

  function automatic op_t make_op(input kind_e k, input logic [47:0] s, input logic [47:0] l,
                                  input logic [5:0] al, input logic [2:0] t);
    op_t o;
    o.kind = k;
    o.start_address = s;
    o.length = l;
    o.align_log2 = al;
    o.region_type = t;
    return o;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(65535, 0)), $urandom()};
  endfunction

  function automatic int short_gap();
    if ($urandom_range(99, 0) < 40) return 0;
    if ($urandom_range(99, 0) < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Addresses mostly stay in a small window so operations hit existing regions.
  function automatic op_t random_op();
    logic [47:0] s, l;
    int r;
    r = $urandom_range(99, 0);
    if (r < 75) begin
      s = 48'($urandom_range(4095, 0));
      l = 48'($urandom_range(256, 1));
    end else if (r < 90) begin
      s = rand48();
      l = rand48() >> $urandom_range(47, 0);
    end else begin
      s = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(300, 0));
      l = 48'($urandom_range(400, 0));
    end
    return make_op(kind_e'(2'($urandom_range(3, 0))), s, l,
                   6'($urandom_range(47, 0) % 13 + ($urandom_range(9, 0) == 0 ? 34 : 0)),
                   3'($urandom_range(7, 0)));
  endfunction

  initial begin
    op_t o;
    // Directed: extremes, every operation, overlap, past top, unknown handle.
    pending_ops.push_back(make_op(KIND_FREE, 48'h0, 48'h0, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_CREATE, 48'h0, 48'h0, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_CREATE, 48'hFFFF_FFFF_FFFF, 48'h1, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_CREATE, 48'hFFFF_FFFF_FFFE, 48'h1, 6'd0, 3'd7));
    pending_ops.push_back(make_op(KIND_CREATE, 48'h0, 48'h1000, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_CREATE, 48'h1000, 48'h1000, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_CREATE, 48'h800, 48'h10, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'h100, 48'h100, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'h100, 48'h100, 6'd0, 3'd3));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'h180, 48'h10, 6'd0, 3'd3));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'h0, 48'h0, 6'd0, 3'd2));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                  6'd63, 3'd1));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'h9000, 48'h10, 6'd0, 3'd2));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'h40, 6'd6, 3'd0));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'h40, 6'd6, 3'd5));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'h0, 6'd0, 3'd1));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'hFFFF_FFFF_FFFF, 6'd47, 3'd1));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'h10, 6'd47, 3'd1));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'h100, 6'd11, 3'd1));
    pending_ops.push_back(make_op(KIND_FREE, 48'h100, 48'h0, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_FREE, 48'h0, 48'h0, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_FREE, 48'hFFFF_FFFF_FFFE, 48'h0, 6'd0, 3'd0));
    pending_ops.push_back(make_op(KIND_FREE, 48'h1234, 48'h0, 6'd0, 3'd0));
    // Fill the table with fragments so the full-table answers are reached.
    for (int i = 0; i < 70; i++)
      pending_ops.push_back(make_op(KIND_CREATE, 48'h10_0000 + i * 48'h20, 48'h10, 6'd0,
                                    3'(1 + i % 7)));
    pending_ops.push_back(make_op(KIND_RESERVE, 48'h10, 48'h10, 6'd0, 3'd2));
    pending_ops.push_back(make_op(KIND_ALLOCATE, 48'h0, 48'h8, 6'd3, 3'd1));
    for (int i = 0; i < 70; i++)
      pending_ops.push_back(make_op(KIND_FREE, 48'h10_0000 + i * 48'h20, 48'h0, 6'd0, 3'd0));
    for (int i = 0; i < 1650; i++) begin
      o = random_op();
      pending_ops.push_back(o);
    end
  end

  // Input transfers are taken at the rising edge and predicted right away.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_answers.push_back(predict_answer(cur_op));
      in_taken = 1'b1;
    end
  end

  // Sender: drives at the falling edge once the current item has gone or none is offered.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        if (pending_ops.size() == 0) all_sent <= 1'b1;
        gap_left = short_gap();
      end
      if (in_taken || !s_axis_tvalid_i) begin
        in_taken = 1'b0;
        if (pending_ops.size() == 900 && hold_request == 0) hold_request = 1;
        if (hold_request == 1 && expected_answers.size() == 0) hold_request = 2;
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (hold_request == 1 || pending_ops.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {7'd0, cur_op.region_type, cur_op.align_log2,
                             cur_op.length, cur_op.start_address};
          s_axis_tuser_i <= cur_op.kind;
        end
      end
    end
  end

  // Receiver: random stalls with runs of none.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(99, 0) < 25) stall_left = short_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %h", m_axis_tdata_o);
      end else begin
        want = expected_answers.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status || m_axis_tdata_o[49:2] !== want.handle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer mismatch: status exp %0d got %0d, handle exp %h got %h",
                     want.status, m_axis_tdata_o[1:0], want.handle, m_axis_tdata_o[49:2]);
        end
      end
    end
  end

  initial begin
    tbl_count = 0;
    gap_left = 0;
    stall_left = 0;
    mismatches = 0;
    all_sent = 1'b0;
    hold_request = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (all_sent && expected_answers.size() == 0 && !s_axis_tvalid_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("sorted_region_table_allocator_tb: PASS");
    end else begin
      $display("sorted_region_table_allocator_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("sorted_region_table_allocator_tb: FAIL");
    $finish;
  end

endmodule
